// ----- hw/rtl/i2c_master_register_access_assert.svh -----
// Assertion macros shared by the I2C master register access RTL.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`ifndef ASSERT_OFF
// Check that the consequent holds in the same cycle as the antecedent.
`define I2CM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define I2CM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// Types, codes and constants of the I2C master register access block.
package i2cm_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int FILL_W    = BUF_AW + 1;

	// Configuration register indexes
	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_GUARD_TICKS = 1'b1;

	// Timing register values after reset
	localparam logic [15:0] PHASE_TICKS_RESET = 16'd32;
	localparam logic [15:0] GUARD_TICKS_RESET = 16'd3200;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_START_FAIL = 2'd1,
		STATUS_NACK       = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_DEV  = 2'd0,
		KIND_SUB  = 2'd1,
		KIND_DATA = 2'd2,
		KIND_RDEV = 2'd3
	} ack_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_S1, ST_S2, ST_S3, ST_R1, ST_R2, ST_R3,
		ST_WLOW, ST_WDATA, ST_WHIGH, ST_WEND,
		ST_A1, ST_A2, ST_A3, ST_A4,
		ST_RLOW, ST_RHIGH,
		ST_M1, ST_M2, ST_M3, ST_M4,
		ST_P1, ST_P2, ST_P3, ST_P4,
		ST_GUARD, ST_DONE
	} step_t;

	// Write port of the byte buffer
	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

	// One result item
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       busy_res;
		logic       done_res;
		status_t    status;
	} result_t;

endpackage

// ----- hw/rtl/i2cm_ram.sv -----
// Generic single-port-write, registered-read RAM.
module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/i2cm_seq.sv -----
// Bus sequencer: bit timing, byte shifting and transaction control.
module i2cm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic [1:0]                 command,
	input  logic                       sda_in,
	input  logic [7:0]                 device_address,
	input  logic [7:0]                 register_address,
	input  logic [7:0]                 length,
	input  logic [7:0]                 write_byte,
	input  logic [15:0]                phase_ticks,
	input  logic [15:0]                guard_ticks,
	output i2cm_pkg::buf_wr_t          buf_wr,
	output logic [i2cm_pkg::BUF_AW-1:0] buf_raddr,
	input  logic [7:0]                 buf_rdata,
	output i2cm_pkg::result_t          res
);

	i2cm_pkg::step_t     step_q, step_d;
	logic [15:0]         wait_q, wait_d;
	logic [3:0]          bitc_q, bitc_d;
	logic [7:0]          left_q, left_d;
	logic [7:0]          sh_q, sh_d;
	logic [i2cm_pkg::FILL_W-1:0] fill_q, fill_d;
	logic [7:0]          ptr_q, ptr_d;
	logic [7:0]          dev_q, dev_d;
	logic [7:0]          reg_q, reg_d;
	logic                rd_q, rd_d;
	logic                scl_q, scl_d;
	logic                sda_q, sda_d;
	i2cm_pkg::ack_kind_t ack_q, ack_d;
	logic                nack_q, nack_d;

	logic [15:0] phase_w;
	logic [3:0]  bitc_inc;
	logic        start;
	logic [7:0]  rx_shift;

	// Wait length after a line change; a zero setting acts as one tick
	assign phase_w  = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;
	assign bitc_inc = bitc_q + 4'd1;
	assign start    = (command == i2cm_pkg::CMD_WRITE) || (command == i2cm_pkg::CMD_READ);
	assign rx_shift = {sh_q[6:0], sda_in};

	// The buffer is only read during a transaction and only written while idle,
	// so the registered read at the current pointer is always up to date at A4
	assign buf_raddr = ptr_q[i2cm_pkg::BUF_AW-1:0];

	// Next step and wait count
	always_comb begin
		step_d = step_q;
		wait_d = wait_q;
		if (step_q == i2cm_pkg::ST_IDLE) begin
			if (start) begin
				step_d = i2cm_pkg::ST_S2;
				wait_d = phase_w;
			end
		end else if (wait_q != 16'd0) begin
			wait_d = wait_q - 16'd1;
		end else begin
			wait_d = phase_w;
			unique case (step_q)
				i2cm_pkg::ST_S1:    step_d = i2cm_pkg::ST_S2;
				i2cm_pkg::ST_R1:    step_d = i2cm_pkg::ST_R2;
				i2cm_pkg::ST_S2: begin
					if (!sda_in) begin
						step_d = i2cm_pkg::ST_IDLE;
						wait_d = 16'd0;
					end else begin
						step_d = i2cm_pkg::ST_S3;
					end
				end
				i2cm_pkg::ST_S3: begin
					if (sda_in) begin
						step_d = i2cm_pkg::ST_IDLE;
						wait_d = 16'd0;
					end else begin
						step_d = i2cm_pkg::ST_WLOW;
					end
				end
				// A failed repeated start runs the first low phase at once
				i2cm_pkg::ST_R2:    step_d = !sda_in ? i2cm_pkg::ST_WDATA : i2cm_pkg::ST_R3;
				i2cm_pkg::ST_R3:    step_d = sda_in ? i2cm_pkg::ST_WDATA : i2cm_pkg::ST_WLOW;
				i2cm_pkg::ST_WLOW:  step_d = i2cm_pkg::ST_WDATA;
				i2cm_pkg::ST_WDATA: step_d = i2cm_pkg::ST_WHIGH;
				i2cm_pkg::ST_WHIGH: step_d = bitc_inc[3] ? i2cm_pkg::ST_WEND : i2cm_pkg::ST_WLOW;
				i2cm_pkg::ST_WEND:  step_d = i2cm_pkg::ST_A1;
				i2cm_pkg::ST_A1:    step_d = i2cm_pkg::ST_A2;
				i2cm_pkg::ST_A2:    step_d = i2cm_pkg::ST_A3;
				i2cm_pkg::ST_A3:    step_d = i2cm_pkg::ST_A4;
				i2cm_pkg::ST_A4: begin
					priority if (ack_q == i2cm_pkg::KIND_DEV) begin
						step_d = sda_in ? i2cm_pkg::ST_P1 : i2cm_pkg::ST_WLOW;
					end else if (ack_q == i2cm_pkg::KIND_SUB && rd_q) begin
						step_d = i2cm_pkg::ST_R1;
					end else if (ack_q == i2cm_pkg::KIND_RDEV) begin
						step_d = (left_q != 8'd0) ? i2cm_pkg::ST_RLOW : i2cm_pkg::ST_P1;
					end else begin
						step_d = (left_q != 8'd0) ? i2cm_pkg::ST_WLOW : i2cm_pkg::ST_P1;
					end
				end
				i2cm_pkg::ST_RLOW:  step_d = bitc_q[3] ? i2cm_pkg::ST_M1 : i2cm_pkg::ST_RHIGH;
				i2cm_pkg::ST_RHIGH: step_d = i2cm_pkg::ST_RLOW;
				i2cm_pkg::ST_M1:    step_d = i2cm_pkg::ST_M2;
				i2cm_pkg::ST_M2:    step_d = i2cm_pkg::ST_M3;
				i2cm_pkg::ST_M3:    step_d = i2cm_pkg::ST_M4;
				i2cm_pkg::ST_M4:    step_d = (left_q != 8'd0) ? i2cm_pkg::ST_RLOW : i2cm_pkg::ST_P1;
				i2cm_pkg::ST_P1:    step_d = i2cm_pkg::ST_P2;
				i2cm_pkg::ST_P2:    step_d = i2cm_pkg::ST_P3;
				i2cm_pkg::ST_P3:    step_d = i2cm_pkg::ST_P4;
				i2cm_pkg::ST_P4:    step_d = nack_q ? i2cm_pkg::ST_DONE : i2cm_pkg::ST_GUARD;
				i2cm_pkg::ST_GUARD: begin
					if (guard_ticks == 16'd0) begin
						step_d = i2cm_pkg::ST_IDLE;
						wait_d = 16'd0;
					end else begin
						step_d = i2cm_pkg::ST_DONE;
						wait_d = guard_ticks - 16'd1;
					end
				end
				default: begin
					step_d = i2cm_pkg::ST_IDLE;
					wait_d = 16'd0;
				end
			endcase
		end
	end

	// Line drive, shifting, counters and result fields
	always_comb begin
		bitc_d = bitc_q;
		left_d = left_q;
		sh_d   = sh_q;
		fill_d = fill_q;
		ptr_d  = ptr_q;
		dev_d  = dev_q;
		reg_d  = reg_q;
		rd_d   = rd_q;
		scl_d  = scl_q;
		sda_d  = sda_q;
		ack_d  = ack_q;
		nack_d = nack_q;
		buf_wr.en   = 1'b0;
		buf_wr.addr = fill_q[i2cm_pkg::BUF_AW-1:0];
		buf_wr.data = write_byte;
		res.read_byte  = 8'd0;
		res.read_valid = 1'b0;
		res.done_res   = 1'b0;
		res.status     = i2cm_pkg::STATUS_OK;
		if (step_q == i2cm_pkg::ST_IDLE) begin
			priority if (command == i2cm_pkg::CMD_LOAD) begin
				// Append to the buffer, drop when full
				if (fill_q < i2cm_pkg::FILL_W'(i2cm_pkg::BUF_DEPTH)) begin
					buf_wr.en = 1'b1;
					fill_d    = fill_q + i2cm_pkg::FILL_W'(1);
				end
			end else if (start) begin
				dev_d  = device_address;
				reg_d  = register_address;
				left_d = length;
				rd_d   = (command == i2cm_pkg::CMD_READ);
				if (command == i2cm_pkg::CMD_WRITE) begin
					fill_d = '0;
				end
				ptr_d  = 8'd0;
				nack_d = 1'b0;
				bitc_d = 4'd0;
				scl_d  = 1'b1;
				sda_d  = 1'b1;
			end
		end else if (wait_q == 16'd0) begin
			unique case (step_q)
				i2cm_pkg::ST_S1, i2cm_pkg::ST_R1: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
				end
				i2cm_pkg::ST_S2: begin
					if (!sda_in) begin
						res.done_res = 1'b1;
						res.status   = i2cm_pkg::STATUS_START_FAIL;
					end else begin
						sda_d = 1'b0;
					end
				end
				i2cm_pkg::ST_S3: begin
					if (sda_in) begin
						res.done_res = 1'b1;
						res.status   = i2cm_pkg::STATUS_START_FAIL;
					end else begin
						sda_d  = 1'b0;
						sh_d   = dev_q;
						ack_d  = i2cm_pkg::KIND_DEV;
						bitc_d = 4'd0;
					end
				end
				i2cm_pkg::ST_R2: begin
					if (!sda_in) begin
						scl_d = 1'b0;
					end else begin
						sda_d = 1'b0;
					end
				end
				i2cm_pkg::ST_R3: begin
					if (sda_in) begin
						scl_d = 1'b0;
					end else begin
						sda_d = 1'b0;
					end
				end
				i2cm_pkg::ST_WLOW, i2cm_pkg::ST_A1, i2cm_pkg::ST_M1, i2cm_pkg::ST_P1: begin
					scl_d = 1'b0;
				end
				i2cm_pkg::ST_WDATA: begin
					sda_d = sh_q[7];
					sh_d  = {sh_q[6:0], 1'b0};
				end
				i2cm_pkg::ST_WHIGH, i2cm_pkg::ST_RHIGH: begin
					scl_d  = 1'b1;
					bitc_d = bitc_inc;
				end
				i2cm_pkg::ST_WEND: begin
					scl_d  = 1'b0;
					bitc_d = 4'd0;
				end
				i2cm_pkg::ST_A2, i2cm_pkg::ST_P4: begin
					sda_d = 1'b1;
				end
				i2cm_pkg::ST_A3, i2cm_pkg::ST_M3, i2cm_pkg::ST_P3: begin
					scl_d = 1'b1;
				end
				i2cm_pkg::ST_A4: begin
					scl_d = 1'b0;
					priority if (ack_q == i2cm_pkg::KIND_DEV) begin
						if (sda_in) begin
							nack_d = 1'b1;
						end else begin
							sh_d   = reg_q;
							ack_d  = i2cm_pkg::KIND_SUB;
							bitc_d = 4'd0;
						end
					end else if (ack_q == i2cm_pkg::KIND_SUB && rd_q) begin
						sh_d   = dev_q | 8'h01;
						ack_d  = i2cm_pkg::KIND_RDEV;
						bitc_d = 4'd0;
					end else if (ack_q == i2cm_pkg::KIND_RDEV) begin
						bitc_d = 4'd0;
						sh_d   = 8'd0;
					end else if (left_q != 8'd0) begin
						// Take the next buffered byte
						sh_d   = buf_rdata;
						ptr_d  = ptr_q + 8'd1;
						left_d = left_q - 8'd1;
						ack_d  = i2cm_pkg::KIND_DATA;
						bitc_d = 4'd0;
					end
				end
				i2cm_pkg::ST_RLOW: begin
					scl_d = 1'b0;
					if (bitc_q != 4'd0) begin
						sh_d = rx_shift;
					end else begin
						sda_d = 1'b1;
					end
					if (bitc_q[3]) begin
						res.read_byte  = rx_shift;
						res.read_valid = 1'b1;
						left_d         = left_q - 8'd1;
						bitc_d         = 4'd0;
					end
				end
				i2cm_pkg::ST_M2: begin
					sda_d = (left_q == 8'd0);
				end
				i2cm_pkg::ST_M4: begin
					scl_d  = 1'b0;
					bitc_d = 4'd0;
					sh_d   = 8'd0;
				end
				i2cm_pkg::ST_P2: begin
					sda_d = 1'b0;
				end
				i2cm_pkg::ST_GUARD: begin
					if (guard_ticks == 16'd0) begin
						res.done_res = 1'b1;
						res.status   = nack_q ? i2cm_pkg::STATUS_NACK : i2cm_pkg::STATUS_OK;
					end
				end
				i2cm_pkg::ST_DONE: begin
					res.done_res = 1'b1;
					res.status   = nack_q ? i2cm_pkg::STATUS_NACK : i2cm_pkg::STATUS_OK;
				end
				default: begin
					res.done_res = 1'b0;
				end
			endcase
		end
		buf_wr.en    = buf_wr.en & acc;
		res.scl_out  = scl_d;
		res.sda_out  = sda_d;
		res.busy_res = (step_d != i2cm_pkg::ST_IDLE);
	end

	// Advance the sequencer on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= i2cm_pkg::ST_IDLE;
			wait_q <= 16'd0;
			bitc_q <= 4'd0;
			left_q <= 8'd0;
			sh_q   <= 8'd0;
			fill_q <= '0;
			ptr_q  <= 8'd0;
			dev_q  <= 8'd0;
			reg_q  <= 8'd0;
			rd_q   <= 1'b0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			ack_q  <= i2cm_pkg::KIND_DEV;
			nack_q <= 1'b0;
		end else if (acc) begin
			step_q <= step_d;
			wait_q <= wait_d;
			bitc_q <= bitc_d;
			left_q <= left_d;
			sh_q   <= sh_d;
			fill_q <= fill_d;
			ptr_q  <= ptr_d;
			dev_q  <= dev_d;
			reg_q  <= reg_d;
			rd_q   <= rd_d;
			scl_q  <= scl_d;
			sda_q  <= sda_d;
			ack_q  <= ack_d;
			nack_q <= nack_d;
		end
	end

endmodule

// ----- hw/rtl/i2cm_out.sv -----
// Output register with a skid stage for the result channel.
module i2cm_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cm_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output i2cm_pkg::result_t  out_data
);

	logic              main_valid_q;
	i2cm_pkg::result_t main_q;
	logic              skid_valid_q;
	i2cm_pkg::result_t skid_q;

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Control: refill the main stage from the skid stage first to keep order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || !out_stall) begin
			main_valid_q <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (!main_valid_q || !out_stall) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- hw/rtl/i2c_master_register_access.sv -----
// Top level of the I2C master register access block.
//
// One request is one bus timing tick: it carries a command (tick, load a
// buffer byte, start a write, start a read) and the sampled SDA level. Every
// accepted request yields exactly one result with the SCL/SDA drive levels,
// a received byte with read_valid, busy_res, done_res and status.
// Requests are taken at one per cycle while in_stall is low; the sequencer
// updates on acceptance and its result is registered in the output or skid stage.
// Bytes to write sit in a 256-entry buffer RAM with a registered read; the
// RAM is read at the buffer pointer every cycle, and only written
// while idle, so the byte is ready when a data byte begins.
// A skid stage behind the output register lets one more request in while
// the receiver stalls; in_stall rises only once both stages hold results.
// Reset (arst_n low) returns the sequencer to idle with both lines released,
// empties the buffer count and restores phase_ticks 32 and guard_ticks 3200.
// Buffer contents are not cleared, so there is no clearing pass.
// Configuration writes take effect at the next edge and are meant for idle.
module i2c_master_register_access (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic        sda_in,
	input  logic [7:0]  device_address,
	input  logic [7:0]  register_address,
	input  logic [7:0]  length,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_out,
	output logic        sda_out,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic        busy_res,
	output logic        done_res,
	output logic [1:0]  status,
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	`include "i2c_master_register_access_assert.svh"

	logic                          acc;
	logic [15:0]                   phase_q;
	logic [15:0]                   guard_q;
	i2cm_pkg::buf_wr_t             buf_wr;
	logic [i2cm_pkg::BUF_AW-1:0]   buf_raddr;
	logic [7:0]                    buf_rdata;
	i2cm_pkg::result_t             res;
	i2cm_pkg::result_t             out_res;

	assign acc = in_valid && !in_stall;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PHASE_TICKS_RESET;
			guard_q <= i2cm_pkg::GUARD_TICKS_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == i2cm_pkg::CFG_PHASE_TICKS) begin
				phase_q <= cfg_data;
			end
			if (cfg_index == i2cm_pkg::CFG_GUARD_TICKS) begin
				guard_q <= cfg_data;
			end
		end
	end

	i2cm_ram #(
		.WIDTH (8),
		.DEPTH (i2cm_pkg::BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (buf_wr.en),
		.waddr (buf_wr.addr),
		.wdata (buf_wr.data),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	i2cm_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.acc              (acc),
		.command          (command),
		.sda_in           (sda_in),
		.device_address   (device_address),
		.register_address (register_address),
		.length           (length),
		.write_byte       (write_byte),
		.phase_ticks      (phase_q),
		.guard_ticks      (guard_q),
		.buf_wr           (buf_wr),
		.buf_raddr        (buf_raddr),
		.buf_rdata        (buf_rdata),
		.res              (res)
	);

	i2cm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign scl_out    = out_res.scl_out;
	assign sda_out    = out_res.sda_out;
	assign read_byte  = out_res.read_byte;
	assign read_valid = out_res.read_valid;
	assign busy_res   = out_res.busy_res;
	assign done_res   = out_res.done_res;
	assign status     = out_res.status;

	// A full skid stage always sits behind a valid output stage
	`I2CM_ASSERT_IMP(a_skid_behind_main, clk, arst_n, in_stall, out_valid, "skid full without output")
	// A received byte completes in the middle of a transaction
	`I2CM_ASSERT_IMP(a_read_while_busy, clk, arst_n, out_valid && read_valid, busy_res, "read byte while idle")
	// Completion leaves the sequencer idle
	`I2CM_ASSERT_IMP(a_done_idle, clk, arst_n, out_valid && done_res, !busy_res, "done while busy")
	// An error code only accompanies completion
	`I2CM_ASSERT_IMP(a_status_done, clk, arst_n, out_valid && (status != i2cm_pkg::STATUS_OK), done_res, "status without done")

endmodule

// ----- bench/i2c_master_register_access_tb.sv -----
// Self-checking testbench for the I2C master register access block.
module i2c_master_register_access_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	localparam int   RANDOM_REQUESTS = 300;
	localparam int   MISMATCH_PRINTS = 40;

	// Percent chances of bus faults and of commands issued while busy
	typedef struct {
		int noise;
		int start_hi;
		int start_lo;
		int rstart_hi;
		int rstart_lo;
		int dev_nack;
		int busy_cmd;
	} fault_mix_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic        sda_in;
	logic [7:0]  device_address;
	logic [7:0]  register_address;
	logic [7:0]  length;
	logic [7:0]  write_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic [7:0]  read_byte;
	logic        read_valid;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic        cfg_write_en;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// Predictor state
	step_t       bus_step;
	logic [15:0] phase_wait;
	logic [3:0]  bit_idx;
	logic [7:0]  bytes_todo;
	logic [7:0]  shift_byte;
	logic [7:0]  tx_bytes [BUF_DEPTH];
	logic [8:0]  tx_fill;
	logic [7:0]  tx_next;
	logic [7:0]  dev_byte;
	logic [7:0]  sub_byte;
	bit          reading;
	bit          scl_drive;
	bit          sda_drive;
	ack_kind_t   acked_kind;
	bit          nacked;
	logic [15:0] phase_len;
	logic [15:0] guard_len;
	int          tx_written;

	result_t     pending_bus_results [$];
	fault_mix_t  faults;
	int unsigned burst_left;
	int unsigned requests_sent;
	int unsigned error_count;
	int unsigned ticks_checked;
	int unsigned done_ok;
	int unsigned done_start_fail;
	int unsigned done_nack;
	int unsigned bytes_read;
	int unsigned timing_sets;
	logic [11:0] stall_cycle = '0;

	i2c_master_register_access uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.sda_in(sda_in),
		.device_address(device_address),
		.register_address(register_address),
		.length(length),
		.write_byte(write_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.read_byte(read_byte),
		.read_valid(read_valid),
		.busy_res(busy_res),
		.done_res(done_res),
		.status(status),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#1_000_000;
		$display("Timed out with %0d results outstanding", pending_bus_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stall the result side in changing patterns
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 12'd1;
		case (stall_cycle[11:10])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(3) == 0);
			2'd2: out_stall <= (stall_cycle[3:0] < 4'd5);
			default: out_stall <= ($urandom_range(1) == 1);
		endcase
	end

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic void next_phase(step_t s);
		phase_wait = (phase_len == 16'd0) ? 16'd0 : phase_len - 16'd1;
		bus_step = s;
	endfunction

	// Advance the bus sequencer by one tick and return the expected result
	function automatic result_t predict_bus_tick(cmd_t cmd, bit sda, logic [7:0] dev,
			logic [7:0] reg_addr, logic [7:0] len, logic [7:0] wb);
		result_t r;
		bit      run;
		bit      again;
		step_t   nxt;
		r = '0;
		run = 1'b0;
		if (bus_step == ST_IDLE) begin
			if (cmd == CMD_LOAD) begin
				if (tx_fill < BUF_DEPTH) begin
					tx_bytes[tx_fill[7:0]] = wb;
					tx_fill++;
					if (tx_fill > tx_written)
						tx_written = tx_fill;
				end
			end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
				dev_byte = dev;
				sub_byte = reg_addr;
				bytes_todo = len;
				reading = (cmd == CMD_READ);
				if (!reading)
					tx_fill = '0;
				tx_next = '0;
				nacked = 1'b0;
				bit_idx = '0;
				bus_step = ST_S1;
				phase_wait = '0;
				run = 1'b1;
			end
		end else if (phase_wait != 16'd0) begin
			phase_wait--;
		end else begin
			run = 1'b1;
		end

		again = run;
		while (again) begin
			again = 1'b0;
			case (bus_step)
				ST_S1, ST_R1: begin
					sda_drive = 1'b1;
					scl_drive = 1'b1;
					next_phase(bus_step == ST_S1 ? ST_S2 : ST_R2);
				end
				ST_S2, ST_S3: begin
					// Bus not free or start not seen: give up without a stop
					if ((bus_step == ST_S2) ? !sda : sda) begin
						r.done_res = 1'b1;
						r.status = STATUS_START_FAIL;
						bus_step = ST_IDLE;
						phase_wait = '0;
					end else begin
						sda_drive = 1'b0;
						if (bus_step == ST_S2) begin
							next_phase(ST_S3);
						end else begin
							shift_byte = dev_byte;
							acked_kind = KIND_DEV;
							bit_idx = '0;
							next_phase(ST_WLOW);
						end
					end
				end
				ST_R2, ST_R3: begin
					// A failed repeated start goes straight on to the byte
					if ((bus_step == ST_R2) ? !sda : sda) begin
						bus_step = ST_WLOW;
						again = 1'b1;
					end else begin
						sda_drive = 1'b0;
						next_phase(bus_step == ST_R2 ? ST_R3 : ST_WLOW);
					end
				end
				ST_WLOW: begin
					scl_drive = 1'b0;
					next_phase(ST_WDATA);
				end
				ST_WDATA: begin
					sda_drive = shift_byte[7];
					shift_byte = {shift_byte[6:0], 1'b0};
					next_phase(ST_WHIGH);
				end
				ST_WHIGH: begin
					scl_drive = 1'b1;
					bit_idx++;
					next_phase(bit_idx >= 4'd8 ? ST_WEND : ST_WLOW);
				end
				ST_WEND: begin
					scl_drive = 1'b0;
					bit_idx = '0;
					next_phase(ST_A1);
				end
				ST_A1: begin
					scl_drive = 1'b0;
					next_phase(ST_A2);
				end
				ST_A2: begin
					sda_drive = 1'b1;
					next_phase(ST_A3);
				end
				ST_A3: begin
					scl_drive = 1'b1;
					next_phase(ST_A4);
				end
				ST_A4: begin
					scl_drive = 1'b0;
					if (acked_kind == KIND_DEV) begin
						if (sda) begin
							nacked = 1'b1;
							nxt = ST_P1;
						end else begin
							shift_byte = sub_byte;
							acked_kind = KIND_SUB;
							bit_idx = '0;
							nxt = ST_WLOW;
						end
					end else if (acked_kind == KIND_SUB && reading) begin
						shift_byte = dev_byte | 8'h01;
						acked_kind = KIND_RDEV;
						bit_idx = '0;
						nxt = ST_R1;
					end else if (acked_kind == KIND_RDEV) begin
						bit_idx = '0;
						shift_byte = '0;
						nxt = (bytes_todo != 0) ? ST_RLOW : ST_P1;
					end else if (bytes_todo != 0) begin
						shift_byte = tx_bytes[tx_next];
						tx_next++;
						bytes_todo--;
						acked_kind = KIND_DATA;
						bit_idx = '0;
						nxt = ST_WLOW;
					end else begin
						nxt = ST_P1;
					end
					next_phase(nxt);
				end
				ST_RLOW: begin
					if (bit_idx != 0)
						shift_byte = {shift_byte[6:0], sda};
					else
						sda_drive = 1'b1;
					scl_drive = 1'b0;
					if (bit_idx >= 4'd8) begin
						r.read_byte = shift_byte;
						r.read_valid = 1'b1;
						bytes_todo--;
						bit_idx = '0;
						next_phase(ST_M1);
					end else begin
						next_phase(ST_RHIGH);
					end
				end
				ST_RHIGH: begin
					scl_drive = 1'b1;
					bit_idx++;
					next_phase(ST_RLOW);
				end
				ST_M1: begin
					scl_drive = 1'b0;
					next_phase(ST_M2);
				end
				ST_M2: begin
					// ACK all but the last byte
					sda_drive = (bytes_todo == 0);
					next_phase(ST_M3);
				end
				ST_M3: begin
					scl_drive = 1'b1;
					next_phase(ST_M4);
				end
				ST_M4: begin
					scl_drive = 1'b0;
					bit_idx = '0;
					shift_byte = '0;
					next_phase(bytes_todo != 0 ? ST_RLOW : ST_P1);
				end
				ST_P1: begin
					scl_drive = 1'b0;
					next_phase(ST_P2);
				end
				ST_P2: begin
					sda_drive = 1'b0;
					next_phase(ST_P3);
				end
				ST_P3: begin
					scl_drive = 1'b1;
					next_phase(ST_P4);
				end
				ST_P4: begin
					sda_drive = 1'b1;
					next_phase(nacked ? ST_DONE : ST_GUARD);
				end
				ST_GUARD: begin
					bus_step = ST_DONE;
					if (guard_len == 16'd0)
						again = 1'b1;
					else
						phase_wait = guard_len - 16'd1;
				end
				ST_DONE: begin
					r.done_res = 1'b1;
					r.status = nacked ? STATUS_NACK : STATUS_OK;
					bus_step = ST_IDLE;
					phase_wait = '0;
				end
				default: begin
					bus_step = ST_IDLE;
					phase_wait = '0;
				end
			endcase
		end

		r.scl_out = scl_drive;
		r.sda_out = sda_drive;
		r.busy_res = (bus_step != ST_IDLE);
		return r;
	endfunction

	// Level a device on the bus would leave on SDA for the next tick
	function automatic bit bus_sda_sample();
		if (roll(faults.noise))
			return $urandom_range(1) == 1;
		case (bus_step)
			ST_S2: return !roll(faults.start_hi);
			ST_S3: return roll(faults.start_lo);
			ST_R2: return !roll(faults.rstart_hi);
			ST_R3: return roll(faults.rstart_lo);
			ST_A4: begin
				if (acked_kind == KIND_DEV)
					return roll(faults.dev_nack);
				return $urandom_range(1) == 1;
			end
			ST_RLOW: begin
				if (bit_idx != 0)
					return $urandom_range(1) == 1;
				return sda_drive;
			end
			default: return sda_drive;
		endcase
	endfunction

	// Send one request in bursts with random gaps, then predict its result
	task automatic send_item(cmd_t cmd, bit sda, logic [7:0] dev, logic [7:0] reg_addr,
			logic [7:0] len, logic [7:0] wb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 64);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		sda_in <= sda;
		device_address <= dev;
		register_address <= reg_addr;
		length <= len;
		write_byte <= wb;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_bus_results.push_back(predict_bus_tick(cmd, sda, dev, reg_addr, len, wb));
		requests_sent++;
	endtask

	// Hold requests until every expected result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_bus_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write both timing registers while the block is idle
	task automatic set_timing(logic [15:0] phase, logic [15:0] guard);
		wait_for_results();
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= phase;
		@(posedge clk);
		cfg_index <= CFG_GUARD_TICKS;
		cfg_data <= guard;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		phase_len = phase;
		guard_len = guard;
		timing_sets++;
	endtask

	task automatic load_byte(logic [7:0] value);
		send_item(CMD_LOAD, bus_sda_sample(), 8'($urandom), 8'($urandom), 8'($urandom), value);
	endtask

	// Start a transaction and tick until the sequencer is idle again
	task automatic run_transaction(cmd_t op, logic [7:0] dev, logic [7:0] reg_addr,
			logic [7:0] len);
		cmd_t cmd;
		send_item(op, bus_sda_sample(), dev, reg_addr, len, 8'($urandom));
		while (bus_step != ST_IDLE) begin
			cmd = roll(faults.busy_cmd) ? cmd_t'($urandom_range(3)) : CMD_TICK;
			send_item(cmd, bus_sda_sample(), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));
			if ($urandom_range(299) == 0)
				wait_for_results();
		end
	endtask

	task automatic test_reset_timing();
		faults = '{default: 0};
		send_item(CMD_TICK, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		load_byte(8'hFF);
		load_byte(8'h00);
		// Bus held low: the start check fails after one phase of reset length
		faults.start_hi = 100;
		run_transaction(CMD_WRITE, 8'hA0, 8'h10, 8'd2);
		faults.start_hi = 0;
	endtask

	task automatic test_write_paths();
		set_timing(16'd1, 16'd0);
		faults = '{default: 0};
		run_transaction(CMD_WRITE, 8'h00, 8'hFF, 8'd0);
		repeat (3) load_byte(8'($urandom));
		// Commands during the transfer must be ignored
		faults.busy_cmd = 40;
		run_transaction(CMD_WRITE, 8'hFE, 8'h00, 8'd3);
		faults.busy_cmd = 0;
		faults.dev_nack = 100;
		run_transaction(CMD_WRITE, 8'h42, 8'h24, 8'd1);
		faults.dev_nack = 0;
	endtask

	task automatic test_read_paths();
		set_timing(16'd1, 16'd5);
		faults = '{default: 0};
		run_transaction(CMD_READ, 8'hFF, 8'h80, 8'd2);
		faults.rstart_hi = 100;
		run_transaction(CMD_READ, 8'h2C, 8'h10, 8'd1);
		faults.rstart_hi = 0;
		faults.rstart_lo = 100;
		run_transaction(CMD_READ, 8'h2D, 8'hC3, 8'd1);
		faults.rstart_lo = 0;
		faults.dev_nack = 100;
		run_transaction(CMD_READ, 8'h77, 8'h08, 8'd4);
		faults.dev_nack = 0;
	endtask

	task automatic test_start_faults();
		faults = '{default: 0};
		faults.start_hi = 100;
		run_transaction(CMD_WRITE, 8'h12, 8'h34, 8'd0);
		faults.start_hi = 0;
		faults.start_lo = 100;
		run_transaction(CMD_READ, 8'h56, 8'h78, 8'd2);
		faults.start_lo = 0;
	endtask

	task automatic test_timing_extremes();
		// A zero phase setting acts as one tick
		set_timing(16'd0, 16'd0);
		faults = '{default: 0};
		run_transaction(CMD_WRITE, 8'h10, 8'h20, 8'd0);
		// Long phase with a failed start, then a long guard wait
		set_timing(16'd120, 16'd0);
		faults.start_hi = 100;
		run_transaction(CMD_WRITE, 8'h10, 8'h20, 8'd0);
		faults.start_hi = 0;
		set_timing(16'd1, 16'd40);
		run_transaction(CMD_WRITE, 8'h66, 8'h99, 8'd0);
	endtask

	task automatic test_buffer_limits();
		set_timing(16'd1, 16'd1);
		faults = '{default: 0};
		// Fill past the depth; the extra loads are dropped
		repeat (BUF_DEPTH + 2) load_byte(8'($urandom));
		run_transaction(CMD_WRITE, 8'hC4, 8'h3C, 8'd2);
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		int          cap;
		logic [7:0]  len;
		stop_at = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < stop_at) begin
			if ($urandom_range(5) == 0)
				set_timing(($urandom_range(7) == 0) ? 16'($urandom_range(4, 9))
						: 16'($urandom_range(1, 3)),
					($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 24)));
			faults = '{noise: 2, start_hi: 5, start_lo: 5, rstart_hi: 10, rstart_lo: 10,
				dev_nack: 15, busy_cmd: 10};
			repeat ($urandom_range(0, 5)) load_byte(8'($urandom));
			repeat ($urandom_range(0, 2))
				send_item(CMD_TICK, bus_sda_sample(), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			case ($urandom_range(9))
				0: ;
				1, 2, 3, 4: begin
					cap = tx_fill;
					if ($urandom_range(7) == 0)
						cap = tx_written;
					if (cap > 12)
						cap = 12;
					len = 8'($urandom_range(0, cap));
					run_transaction(CMD_WRITE, 8'($urandom), 8'($urandom), len);
				end
				default: begin
					len = ($urandom_range(9) == 0) ? 8'($urandom_range(5, 16))
						: 8'($urandom_range(0, 4));
					run_transaction(CMD_READ, 8'($urandom), 8'($urandom), len);
				end
			endcase
		end
	endtask

	task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MISMATCH_PRINTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Compare each returned result with the oldest prediction
	always @(posedge clk) begin : watch_results
		result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_bus_results.size() == 0) begin
				error_count++;
				if (error_count <= MISMATCH_PRINTS)
					$display("%0t: unexpected result, expected none, got scl %0b sda %0b",
						$time, scl_out, sda_out);
			end else begin
				want = pending_bus_results.pop_front();
				ticks_checked++;
				check_field("scl_out", 8'(want.scl_out), 8'(scl_out));
				check_field("sda_out", 8'(want.sda_out), 8'(sda_out));
				check_field("read_byte", want.read_byte, read_byte);
				check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
				check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
				check_field("done_res", 8'(want.done_res), 8'(done_res));
				check_field("status", 8'(want.status), 8'(status));
				if (want.read_valid)
					bytes_read++;
				if (want.done_res) begin
					case (want.status)
						STATUS_OK: done_ok++;
						STATUS_START_FAIL: done_start_fail++;
						default: done_nack++;
					endcase
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_TICK;
		sda_in <= 1'b1;
		device_address <= '0;
		register_address <= '0;
		length <= '0;
		write_byte <= '0;
		cfg_write_en <= 1'b0;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= '0;

		// Predictor starts from the reset state
		bus_step = ST_IDLE;
		phase_wait = '0;
		bit_idx = '0;
		bytes_todo = '0;
		shift_byte = '0;
		tx_fill = '0;
		tx_next = '0;
		dev_byte = '0;
		sub_byte = '0;
		reading = 1'b0;
		scl_drive = 1'b1;
		sda_drive = 1'b1;
		acked_kind = KIND_DEV;
		nacked = 1'b0;
		phase_len = PHASE_TICKS_RESET;
		guard_len = GUARD_TICKS_RESET;
		tx_written = 0;
		faults = '{default: 0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_timing();
		test_write_paths();
		test_read_paths();
		test_start_faults();
		test_timing_extremes();
		test_buffer_limits();
		test_random_traffic();

		wait_for_results();
		repeat (6) @(posedge clk);

		$display("Checked %0d bus ticks: %0d transfers ok, %0d start failures, %0d device NACKs",
			ticks_checked, done_ok, done_start_fail, done_nack);
		$display("Received %0d read bytes under %0d timing settings", bytes_read, timing_sets);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- i2c_master_register_access.f -----
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_ram.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2cm_out.sv
hw/rtl/i2c_master_register_access.sv
bench/i2c_master_register_access_tb.sv
